[rtl/itok_pkg.sv]
`default_nettype none

package itok_pkg;

    // Highest parameter index, and the saturation point of the 4-bit counter.
    localparam int unsigned MAX_PARAM_INDEX = 15;
    localparam int unsigned PARAM_LIMIT_INT = (MAX_PARAM_INDEX < 15) ? MAX_PARAM_INDEX : 15;
    localparam logic [3:0]  PARAM_LIMIT     = PARAM_LIMIT_INT[3:0];

    // Depth of the queue between the classifier and the output stage.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // Characters with a special meaning.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    // Role of a byte within the message.
    typedef enum logic [2:0] {
        ROLE_PREFIX = 3'd0,
        ROLE_CMD    = 3'd1,
        ROLE_PARAM  = 3'd2,
        ROLE_TRAIL  = 3'd3,
        ROLE_SEP    = 3'd4
    } role_t;

    // One result as delivered on the output channel.
    typedef struct packed {
        logic [7:0] char_byte;
        role_t      role;
        logic [3:0] param_index;
        logic       nonprintable;
        logic       token_end;
        logic       message_end;
        logic       last_of_run;
    } res_t;

    // One queue entry: the one or two results caused by an input byte.
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } entry_t;

    // Queue status seen by the output stage and the classifier.
    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    function automatic res_t mk_res(input logic [7:0] b, input role_t role,
                                    input logic [3:0] idx, input logic np,
                                    input logic te, input logic me);
        res_t r;
        r.char_byte    = b;
        r.role         = role;
        r.param_index  = idx;
        r.nonprintable = np;
        r.token_end    = te;
        r.message_end  = me;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/itok_in_if.sv]
`default_nettype none

interface itok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

`default_nettype wire

[rtl/itok_out_if.sv]
`default_nettype none

interface itok_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic [2:0] role;
    logic [3:0] param_index;
    logic       nonprintable;
    logic       token_end;
    logic       message_end;
    logic       last_of_run;

    modport source (output valid, output char_byte, output role, output param_index,
                    output nonprintable, output token_end, output message_end,
                    output last_of_run, input ready);
    modport sink   (input valid, input char_byte, input role, input param_index,
                    input nonprintable, input token_end, input message_end,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/itok_front.sv]
`default_nettype none

module itok_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    itok_in_if.sink             byte_in,
    input  wire itok_pkg::qstat_t qstat,
    output      logic           push,
    output      itok_pkg::entry_t push_entry
);
    import itok_pkg::*;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_PREFIX  = 3'd1,
        PH_CMD     = 3'd2,
        PH_PSTART  = 3'd3,
        PH_PARAM   = 3'd4,
        PH_TRAIL   = 3'd5,
        PH_DISCARD = 3'd6
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       held_reg, held_next;
    logic [3:0] cnt_reg, cnt_next;

    logic [7:0] b;
    logic       term;
    logic       np;
    logic       accept;
    logic [1:0] n;
    logic       slot;
    logic       last_sel;
    res_t       r [2];

    assign b      = byte_in.data_byte;
    assign term   = !((b >= CH_BANG) && (b <= CH_TILDE));
    assign np     = !((b >= CH_SPACE) && (b <= CH_TILDE));
    assign accept = byte_in.valid && byte_in.ready;

    // The queue takes a byte whenever it has a free entry.
    assign byte_in.ready = !qstat.full;

    // Classify the byte and work out the next parse state.
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        cnt_next   = cnt_reg;
        n          = 2'd0;
        slot       = 1'b0;
        r[0]       = '0;
        r[1]       = '0;
        unique case (phase_reg)
            PH_PREFIX:
            begin
                n = 2'd1;
                if (term)
                begin
                    r[0]       = mk_res(b, ROLE_SEP, cnt_reg, 1'b0, 1'b1, 1'b0);
                    phase_next = PH_CMD;
                end
                else
                begin
                    r[0] = mk_res(b, ROLE_PREFIX, cnt_reg, 1'b0, 1'b0, 1'b0);
                end
            end
            PH_CMD:
            begin
                n = 2'd1;
                if (term)
                begin
                    r[0]       = mk_res(b, ROLE_SEP, cnt_reg, 1'b0, 1'b1, 1'b0);
                    phase_next = PH_PSTART;
                end
                else
                begin
                    r[0] = mk_res(b, ROLE_CMD, cnt_reg, 1'b0, 1'b0, 1'b0);
                end
            end
            PH_PSTART:
            begin
                n = 2'd1;
                if (term)
                begin
                    // An empty parameter closes the message.
                    r[0]       = mk_res(b, ROLE_SEP, cnt_reg, 1'b0, 1'b1, 1'b1);
                    phase_next = PH_START;
                    cnt_next   = '0;
                    held_next  = 1'b0;
                end
                else if (b == CH_COLON)
                begin
                    r[0]       = mk_res(b, ROLE_SEP, cnt_reg, 1'b0, 1'b0, 1'b0);
                    phase_next = PH_TRAIL;
                end
                else
                begin
                    r[0]       = mk_res(b, ROLE_PARAM, cnt_reg, 1'b0, 1'b0, 1'b0);
                    phase_next = PH_PARAM;
                end
            end
            PH_PARAM:
            begin
                n = 2'd1;
                if (term)
                begin
                    r[0]       = mk_res(b, ROLE_SEP, cnt_reg, 1'b0, 1'b1, 1'b0);
                    phase_next = PH_PSTART;
                    if (cnt_reg < PARAM_LIMIT)
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                else
                begin
                    r[0] = mk_res(b, ROLE_PARAM, cnt_reg, 1'b0, 1'b0, 1'b0);
                end
            end
            PH_TRAIL:
            begin
                if (held_reg && (b == CH_LF))
                begin
                    // CR LF closes the message.
                    r[0]       = mk_res(CH_CR, ROLE_SEP, cnt_reg, 1'b0, 1'b0, 1'b0);
                    r[1]       = mk_res(b, ROLE_SEP, cnt_reg, 1'b0, 1'b1, 1'b1);
                    n          = 2'd2;
                    phase_next = PH_START;
                    cnt_next   = '0;
                    held_next  = 1'b0;
                end
                else
                begin
                    // A lone held CR comes out late as content.
                    if (held_reg)
                    begin
                        r[0]      = mk_res(CH_CR, ROLE_TRAIL, cnt_reg, 1'b1, 1'b0, 1'b0);
                        n         = 2'd1;
                        slot      = 1'b1;
                        held_next = 1'b0;
                    end
                    if (b == CH_NUL)
                    begin
                        r[slot]    = mk_res(b, ROLE_SEP, cnt_reg, 1'b0, 1'b1, 1'b1);
                        n          = n + 2'd1;
                        phase_next = PH_DISCARD;
                        cnt_next   = '0;
                    end
                    else if (b == CH_CR)
                    begin
                        held_next = 1'b1;
                    end
                    else
                    begin
                        r[slot] = mk_res(b, ROLE_TRAIL, cnt_reg, np, 1'b0, 1'b0);
                        n       = n + 2'd1;
                    end
                end
            end
            PH_DISCARD:
            begin
                n          = 2'd1;
                r[0]       = mk_res(b, ROLE_SEP, cnt_reg, 1'b0, 1'b0, 1'b0);
                phase_next = PH_START;
            end
            default:
            begin
                // Message start; an unused code behaves the same way.
                n         = 2'd1;
                cnt_next  = '0;
                held_next = 1'b0;
                if (b == CH_COLON)
                begin
                    r[0]       = mk_res(b, ROLE_SEP, 4'd0, 1'b0, 1'b0, 1'b0);
                    phase_next = PH_PREFIX;
                end
                else if (term)
                begin
                    r[0]       = mk_res(b, ROLE_SEP, 4'd0, 1'b0, 1'b1, 1'b0);
                    phase_next = PH_PSTART;
                end
                else
                begin
                    r[0]       = mk_res(b, ROLE_CMD, 4'd0, 1'b0, 1'b0, 1'b0);
                    phase_next = PH_CMD;
                end
            end
        endcase

        // End of data flushes a held CR and closes whatever is open.
        if (byte_in.end_of_data)
        begin
            if (held_next)
            begin
                r[n[0]] = mk_res(CH_CR, ROLE_TRAIL, cnt_reg, 1'b1, 1'b0, 1'b0);
                n       = n + 2'd1;
            end
            phase_next = PH_START;
            cnt_next   = '0;
            held_next  = 1'b0;
        end

        last_sel = (n == 2'd2);
        if (n != 2'd0)
        begin
            r[last_sel].last_of_run = 1'b1;
            if (byte_in.end_of_data)
            begin
                r[last_sel].token_end   = 1'b1;
                r[last_sel].message_end = 1'b1;
            end
        end
    end

    // A byte that only holds a CR leaves nothing in the queue.
    assign push          = accept && (n != 2'd0);
    assign push_entry.two = last_sel;
    assign push_entry.r0  = r[0];
    assign push_entry.r1  = r[1];

    // Parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            held_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/itok_queue.sv]
`default_nettype none

module itok_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire itok_pkg::entry_t push_entry,
    input  wire logic             pop,
    output      itok_pkg::entry_t head,
    output      itok_pkg::qstat_t qstat
);
    import itok_pkg::*;

    entry_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      wptr_reg, rptr_reg;
    logic [QPTR_W:0]        count_reg;

    assign head        = mem_reg[rptr_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/itok_back.sv]
`default_nettype none

module itok_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire itok_pkg::entry_t head,
    input  wire itok_pkg::qstat_t qstat,
    output      logic             pop,
    itok_out_if.source            token_out
);
    import itok_pkg::*;

    logic valid_reg;
    logic sel_reg;
    res_t res_reg;
    logic load;

    // Load the output register when it is empty or being drained.
    assign load = !qstat.empty && (!valid_reg || token_out.ready);
    assign pop  = load && (sel_reg || !head.two);

    // Output register and second-result select.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                sel_reg   <= !sel_reg && head.two;
            end
            else if (token_out.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= sel_reg ? head.r1 : head.r0;
        end
    end

    assign token_out.valid        = valid_reg;
    assign token_out.char_byte    = res_reg.char_byte;
    assign token_out.role         = 3'(res_reg.role);
    assign token_out.param_index  = res_reg.param_index;
    assign token_out.nonprintable = res_reg.nonprintable;
    assign token_out.token_end    = res_reg.token_end;
    assign token_out.message_end  = res_reg.message_end;
    assign token_out.last_of_run  = res_reg.last_of_run;

endmodule

`default_nettype wire

[rtl/irc_message_tokenizer.sv]
// Channel    Dir  Payload
// byte_in    in   data_byte[7:0], end_of_data
// token_out  out  char_byte[7:0], role[2:0], param_index[3:0], nonprintable,
//                 token_end, message_end, last_of_run
//
// A byte is classified in the cycle it is transferred; its one or two results
// reach token_out through a four-entry queue and a registered output stage.
// One byte per cycle is sustained while token_out is ready and each byte
// yields one result; a CR LF pair or a late CR can yield two, which the single
// output register sends one at a time. Reset is asynchronous, active low, and
// empties the queue. A stall on token_out backs up into byte_in only once the
// queue is full.
`default_nettype none

module irc_message_tokenizer (
    input  wire logic clk,
    input  wire logic rst_n,
    itok_in_if.sink   byte_in,
    itok_out_if.source token_out
);
    import itok_pkg::*;

    qstat_t qstat;
    logic   push;
    logic   pop;
    entry_t push_entry;
    entry_t head;

    itok_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    itok_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    itok_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .token_out (token_out)
    );

endmodule

`default_nettype wire

[rtl/itok_checker.sv]
`default_nettype none

module itok_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] out_role,
    input wire logic [3:0] out_param_index,
    input wire logic       out_nonprintable,
    input wire logic       out_token_end,
    input wire logic       out_message_end,
    input wire logic       out_last_of_run
);
    import itok_pkg::*;

    // A result waits on the channel until it is transferred.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    // A finished message always closes its field and its byte's run.
    a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_message_end |-> out_token_end && out_last_of_run)
        else $error("message end without token end or last of run");

    // Only trailing text carries the nonprintable flag.
    a_np: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_nonprintable |-> out_role == 3'(ROLE_TRAIL))
        else $error("nonprintable flag outside trailing text");

    // Prefix and command bytes always come before the first parameter.
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_role == 3'(ROLE_PREFIX) || out_role == 3'(ROLE_CMD))
        |-> out_param_index == 4'd0)
        else $error("parameter index set in prefix or command");

endmodule

bind irc_message_tokenizer itok_checker u_itok_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (token_out.valid),
    .out_ready        (token_out.ready),
    .out_role         (token_out.role),
    .out_param_index  (token_out.param_index),
    .out_nonprintable (token_out.nonprintable),
    .out_token_end    (token_out.token_end),
    .out_message_end  (token_out.message_end),
    .out_last_of_run  (token_out.last_of_run)
);

`default_nettype wire
